// File: src/ffpa_pkg.sv
// Shared constants, status and command codes, and the memory control group
// for the first-fit page allocator. No dependencies.
package ffpa_pkg;

    localparam int unsigned MAX_PAGES_DEF = 1024;
    localparam int unsigned CNT_W         = 11;
    localparam int unsigned IDX_W         = 10;
    localparam int unsigned ST_W          = 3;

    localparam logic [CNT_W-1:0] REGION_RST = 11'd1024;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_NO_SPACE = 3'd1;
    localparam logic [ST_W-1:0] ST_ZERO     = 3'd2;
    localparam logic [ST_W-1:0] ST_DOUBLE   = 3'd3;
    localparam logic [ST_W-1:0] ST_NULL     = 3'd4;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_free;
        logic wr_cont;
    } t_mem_ctl;

endpackage

// File: src/ffpa_mem.sv
// Page flag store: one free flag and one continuation flag per page,
// one write port and one registered read port. Depends on ffpa_pkg.
module ffpa_mem #(
    parameter int unsigned MAX_PAGES = ffpa_pkg::MAX_PAGES_DEF
) (
    input  logic                         i_clk,
    input  ffpa_pkg::t_mem_ctl           i_ctl,
    input  logic [$clog2(MAX_PAGES)-1:0] i_wr_addr,
    input  logic [$clog2(MAX_PAGES)-1:0] i_rd_addr,
    output logic                         o_rd_free,
    output logic                         o_rd_cont
);

    logic [1:0] r_mem [MAX_PAGES];
    logic [1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= {i_ctl.wr_free, i_ctl.wr_cont};
        end
        if (i_ctl.rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_free = r_rd[1];
    assign o_rd_cont = r_rd[0];

endmodule

// File: src/ffpa_ctrl.sv
// Sequencer for the allocator: clear pass, first-fit scan, run marking and
// block walk on free, over the flag store. Depends on ffpa_pkg.
module ffpa_ctrl #(
    parameter int unsigned MAX_PAGES = ffpa_pkg::MAX_PAGES_DEF,
    localparam int unsigned AW = $clog2(MAX_PAGES),
    localparam int unsigned CW = $clog2(MAX_PAGES + 1),
    localparam int unsigned LW = (CW > ffpa_pkg::CNT_W) ? CW : ffpa_pkg::CNT_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [LW-1:0]              i_limit,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_command,
    input  logic [ffpa_pkg::CNT_W-1:0] i_count,
    input  logic [ffpa_pkg::IDX_W-1:0] i_page_index,
    input  logic                       i_null_handle,
    output ffpa_pkg::t_mem_ctl         o_mem,
    output logic [AW-1:0]              o_wr_addr,
    output logic [AW-1:0]              o_rd_addr,
    input  logic                       i_rd_free,
    input  logic                       i_rd_cont,
    output logic                       o_res_valid,
    input  logic                       i_res_take,
    output logic [ffpa_pkg::ST_W-1:0]  o_res_status,
    output logic [ffpa_pkg::IDX_W-1:0] o_res_first
);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_MARK = 3'd3;
    localparam logic [2:0] S_FRD  = 3'd4;
    localparam logic [2:0] S_FCHK = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    localparam logic [LW-1:0] LMAX  = LW'(MAX_PAGES);
    localparam logic [LW-1:0] LLAST = LW'(MAX_PAGES - 1);

    logic [2:0]                r_state, n_state;
    logic [LW-1:0]             r_ptr, n_ptr;
    logic [LW-1:0]             r_cur, n_cur;
    logic                      r_dv, n_dv;
    logic [LW-1:0]             r_run, n_run;
    logic [LW-1:0]             r_cnt, n_cnt;
    logic [LW-1:0]             r_wp, n_wp;
    logic [LW-1:0]             r_end, n_end;
    logic [LW-1:0]             r_first, n_first;
    logic [ffpa_pkg::ST_W-1:0] r_status, n_status;

    logic [LW-1:0] run_nx;
    logic [LW-1:0] wp_inc;
    logic [LW-1:0] cnt_in;
    logic [LW-1:0] idx_in;

    assign run_nx = i_rd_free ? (r_run + LW'(1)) : '0;
    assign wp_inc = r_wp + LW'(1);
    assign cnt_in = LW'(i_count);
    assign idx_in = LW'(i_page_index);

    always_comb begin
        n_state  = r_state;
        n_ptr    = r_ptr;
        n_cur    = r_cur;
        n_dv     = r_dv;
        n_run    = r_run;
        n_cnt    = r_cnt;
        n_wp     = r_wp;
        n_end    = r_end;
        n_first  = r_first;
        n_status = r_status;
        o_mem     = '0;
        o_wr_addr = r_wp[AW-1:0];
        o_rd_addr = r_ptr[AW-1:0];
        case (r_state)
            S_CLR: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_free = 1'b1;
                if (r_wp == LLAST) begin
                    n_wp    = '0;
                    n_state = S_IDLE;
                end else begin
                    n_wp = wp_inc;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_first = '0;
                    if (i_command == ffpa_pkg::CMD_ALLOC) begin
                        if (cnt_in == '0) begin
                            n_status = ffpa_pkg::ST_ZERO;
                            n_state  = S_DONE;
                        end else if (cnt_in > i_limit) begin
                            n_status = ffpa_pkg::ST_NO_SPACE;
                            n_state  = S_DONE;
                        end else begin
                            n_cnt   = cnt_in;
                            n_ptr   = '0;
                            n_dv    = 1'b0;
                            n_run   = '0;
                            n_state = S_SCAN;
                        end
                    end else begin
                        if (i_null_handle) begin
                            n_status = ffpa_pkg::ST_NULL;
                            n_state  = S_DONE;
                        end else if (idx_in >= LMAX) begin
                            n_status = ffpa_pkg::ST_DOUBLE;
                            n_state  = S_DONE;
                        end else begin
                            n_wp    = idx_in;
                            n_state = S_FRD;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (r_ptr < i_limit) begin
                    o_mem.rd_en = 1'b1;
                    n_ptr       = r_ptr + LW'(1);
                    n_dv        = 1'b1;
                    n_cur       = r_ptr;
                end else begin
                    n_dv = 1'b0;
                end
                if (r_dv) begin
                    if (run_nx == r_cnt) begin
                        n_wp    = r_cur + LW'(1) - r_cnt;
                        n_first = r_cur + LW'(1) - r_cnt;
                        n_end   = r_cur;
                        n_dv    = 1'b0;
                        n_state = S_MARK;
                    end else begin
                        n_run = run_nx;
                    end
                end else if (r_ptr >= i_limit) begin
                    n_status = ffpa_pkg::ST_NO_SPACE;
                    n_state  = S_DONE;
                end
            end
            S_MARK: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_free = 1'b0;
                o_mem.wr_cont = (r_wp != r_end);
                if (r_wp == r_end) begin
                    n_status = ffpa_pkg::ST_OK;
                    n_state  = S_DONE;
                end else begin
                    n_wp = wp_inc;
                end
            end
            S_FRD: begin
                o_mem.rd_en = 1'b1;
                o_rd_addr   = r_wp[AW-1:0];
                n_state     = S_FCHK;
            end
            S_FCHK: begin
                if (i_rd_free) begin
                    n_status = ffpa_pkg::ST_DOUBLE;
                    n_state  = S_DONE;
                end else begin
                    o_mem.wr_en   = 1'b1;
                    o_mem.wr_free = 1'b1;
                    o_mem.wr_cont = 1'b0;
                    if (i_rd_cont && (r_wp != LLAST)) begin
                        o_mem.rd_en = 1'b1;
                        o_rd_addr   = wp_inc[AW-1:0];
                        n_wp        = wp_inc;
                    end else begin
                        n_status = ffpa_pkg::ST_OK;
                        n_state  = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_dv    <= 1'b0;
            r_wp    <= '0;
        end else begin
            r_state <= n_state;
            r_dv    <= n_dv;
            r_wp    <= n_wp;
        end
        r_ptr    <= n_ptr;
        r_cur    <= n_cur;
        r_run    <= n_run;
        r_cnt    <= n_cnt;
        r_end    <= n_end;
        r_first  <= n_first;
        r_status <= n_status;
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);
    assign o_res_status = r_status;
    assign o_res_first  = r_first[ffpa_pkg::IDX_W-1:0];

    a_no_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem.rd_en && o_mem.wr_en) |-> (o_rd_addr != o_wr_addr))
        else $error("read and write hit the same page");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ((r_ptr <= i_limit) && (r_run < r_cnt)))
        else $error("scan pointer or run beyond bound");

    a_mark_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK) |-> (r_wp <= r_end))
        else $error("marking passed end of run");

    a_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res_status != ffpa_pkg::ST_OK)) |-> (o_res_first == '0))
        else $error("first page set on failed command");

    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_take) |=> (o_res_valid && $stable(o_res_status)))
        else $error("result dropped before taken");

endmodule

// File: src/first_fit_page_allocator_core.sv
// Top level of the first-fit page allocator: region register, result
// register and the sequencer over the flag store. Depends on ffpa_pkg,
// ffpa_mem and ffpa_ctrl.
//
//   channel  dir  handshake                 beat
//   cfg      in   i_cfg_valid / o_cfg_ready  i_cfg_data (region_pages)
//   cmd      in   i_valid / o_ready          i_command, i_count, i_page_index, i_null_handle
//   result   out  o_valid / i_ready          o_status, o_first_page
//
// After reset a clearing pass writes every page free, with o_ready low.
// Allocate: a first-fit scan and marking of the flag memory, one page per
// cycle. Free: walks the block through its continuation flags. Zero count,
// oversize count and null or out-of-range free go straight to the result.
// One command is in flight at a time; the result register lets the next
// command start while a beat waits on i_ready.
module first_fit_page_allocator_core #(
    parameter int unsigned MAX_PAGES = ffpa_pkg::MAX_PAGES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [ffpa_pkg::CNT_W-1:0] i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_command,
    input  logic [ffpa_pkg::CNT_W-1:0] i_count,
    input  logic [ffpa_pkg::IDX_W-1:0] i_page_index,
    input  logic                       i_null_handle,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [ffpa_pkg::ST_W-1:0]  o_status,
    output logic [ffpa_pkg::IDX_W-1:0] o_first_page
);

    localparam int unsigned AW = $clog2(MAX_PAGES);
    localparam int unsigned CW = $clog2(MAX_PAGES + 1);
    localparam int unsigned LW = (CW > ffpa_pkg::CNT_W) ? CW : ffpa_pkg::CNT_W;
    localparam logic [LW-1:0] LMAX = LW'(MAX_PAGES);

    logic [ffpa_pkg::CNT_W-1:0] r_region;
    logic [LW-1:0]              region_ext;
    logic [LW-1:0]              limit;

    logic                       r_out_valid;
    logic [ffpa_pkg::ST_W-1:0]  r_status;
    logic [ffpa_pkg::IDX_W-1:0] r_first;

    ffpa_pkg::t_mem_ctl         mem_ctl;
    logic [AW-1:0]              wr_addr;
    logic [AW-1:0]              rd_addr;
    logic                       rd_free;
    logic                       rd_cont;
    logic                       res_valid;
    logic                       res_take;
    logic [ffpa_pkg::ST_W-1:0]  res_status;
    logic [ffpa_pkg::IDX_W-1:0] res_first;

    assign o_cfg_ready = 1'b1;
    assign region_ext  = LW'(r_region);
    assign limit       = (region_ext > LMAX) ? LMAX : region_ext;
    assign res_take    = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region    <= ffpa_pkg::REGION_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_region <= i_cfg_data;
            end
            if (res_valid && res_take) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (res_valid && res_take) begin
            r_status <= res_status;
            r_first  <= res_first;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_first_page = r_first;

    ffpa_mem #(
        .MAX_PAGES (MAX_PAGES)
    ) u_mem (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_wr_addr (wr_addr),
        .i_rd_addr (rd_addr),
        .o_rd_free (rd_free),
        .o_rd_cont (rd_cont)
    );

    ffpa_ctrl #(
        .MAX_PAGES (MAX_PAGES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_limit       (limit),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_command     (i_command),
        .i_count       (i_count),
        .i_page_index  (i_page_index),
        .i_null_handle (i_null_handle),
        .o_mem         (mem_ctl),
        .o_wr_addr     (wr_addr),
        .o_rd_addr     (rd_addr),
        .i_rd_free     (rd_free),
        .i_rd_cont     (rd_cont),
        .o_res_valid   (res_valid),
        .i_res_take    (res_take),
        .o_res_status  (res_status),
        .o_res_first   (res_first)
    );

endmodule

// File: verif/ffpa_result_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the first-fit page allocator: mirrors the page flags and the
// region register, predicts the status beat for every command, compares results.
// Depends on ffpa_pkg.
module ffpa_result_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [ffpa_pkg::CNT_W-1:0] i_cfg_data,
    input  logic                       i_cmd_valid,
    input  logic                       i_cmd_ready,
    input  logic                       i_command,
    input  logic [ffpa_pkg::CNT_W-1:0] i_count,
    input  logic [ffpa_pkg::IDX_W-1:0] i_page_index,
    input  logic                       i_null_handle,
    input  logic                       i_res_valid,
    input  logic                       i_res_ready,
    input  logic [ffpa_pkg::ST_W-1:0]  i_status,
    input  logic [ffpa_pkg::IDX_W-1:0] i_first_page,
    output int                         o_fail_count,
    output int                         o_pending
);
    import ffpa_pkg::*;

    localparam int unsigned PAGES = MAX_PAGES_DEF;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [IDX_W-1:0] first_page;
    } t_alloc_result;

    bit               page_free [PAGES];
    bit               page_link [PAGES];
    logic [CNT_W-1:0] region_pages;
    t_alloc_result    awaited_results [$];
    int               fail_n = 0;

    function automatic t_alloc_result claim_first_fit(input logic [CNT_W-1:0] want);
        t_alloc_result res;
        int unsigned   lim;
        int unsigned   run;
        int unsigned   first;
        bit            found;
        res = '{status: ST_NO_SPACE, first_page: '0};
        lim = (int'(region_pages) > PAGES) ? PAGES : int'(region_pages);
        run = 0;
        found = 1'b0;
        if (want == '0) begin
            res.status = ST_ZERO;
        end else if (int'(want) <= lim) begin
            for (int unsigned i = 0; i < lim && !found; i++) begin
                run = page_free[i] ? run + 1 : 0;
                if (run == int'(want)) begin
                    first = i + 1 - int'(want);
                    for (int unsigned k = first; k <= i; k++) begin
                        page_free[k] = 1'b0;
                        page_link[k] = (k != i);
                    end
                    res.status = ST_OK;
                    res.first_page = IDX_W'(first);
                    found = 1'b1;
                end
            end
        end
        return res;
    endfunction

    function automatic t_alloc_result release_block(input logic [IDX_W-1:0] head,
                                                    input logic is_null);
        t_alloc_result res;
        int unsigned   p;
        bit            more;
        bit            done;
        res = '{status: ST_OK, first_page: '0};
        p = int'(head);
        done = 1'b0;
        if (is_null) begin
            res.status = ST_NULL;
        end else if (p >= PAGES) begin
            res.status = ST_DOUBLE;
        end else begin
            while (!done) begin
                if (page_free[p]) begin
                    res.status = ST_DOUBLE;
                    done = 1'b1;
                end else begin
                    more = page_link[p];
                    page_free[p] = 1'b1;
                    page_link[p] = 1'b0;
                    if (!more || p + 1 >= PAGES) begin
                        done = 1'b1;
                    end else begin
                        p++;
                    end
                end
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_alloc_result got;
        t_alloc_result want;
        if (!i_rst_n) begin
            foreach (page_free[i]) begin
                page_free[i] = 1'b1;
                page_link[i] = 1'b0;
            end
            region_pages = REGION_RST;
            awaited_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                region_pages = i_cfg_data;
            end
            // check the result beat before queuing this edge's command
            if (i_res_valid && i_res_ready) begin
                got = '{status: i_status, first_page: i_first_page};
                if (awaited_results.size() == 0) begin
                    fail_n++;
                    if (fail_n <= 10) begin
                        $display("%0t: result beat with none expected: status %0d first_page %0d",
                                 $time, got.status, got.first_page);
                    end
                end else begin
                    want = awaited_results.pop_front();
                    if (got.status !== want.status || got.first_page !== want.first_page) begin
                        fail_n++;
                        if (fail_n <= 10) begin
                            $display("%0t: status exp %0d got %0d, first_page exp %0d got %0d",
                                     $time, want.status, got.status,
                                     want.first_page, got.first_page);
                        end
                    end
                end
            end
            if (i_cmd_valid && i_cmd_ready) begin
                if (i_command == CMD_ALLOC) begin
                    awaited_results.push_back(claim_first_fit(i_count));
                end else begin
                    awaited_results.push_back(release_block(i_page_index, i_null_handle));
                end
            end
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= fail_n;
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// Top of the first-fit page allocator testbench: clock, reset, command and
// region stimulus, result acceptance and verdict. Depends on ffpa_pkg,
// ffpa_result_checker and first_fit_page_allocator_core.
module tb;
    import ffpa_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int PHASES      = 8;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CNT_W-1:0]   i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic               i_command;
    logic [CNT_W-1:0]   i_count;
    logic [IDX_W-1:0]   i_page_index;
    logic               i_null_handle;
    logic               o_valid;
    logic               i_ready;
    logic [ST_W-1:0]    o_status;
    logic [IDX_W-1:0]   o_first_page;

    int                 fail_count;
    int                 pending;
    int                 send_calm = 0;
    int                 recv_calm = 0;
    bit                 sent_alloc [$];
    logic [IDX_W-1:0]   live_blocks [$];
    int unsigned        phase_region [PHASES] = '{64, 0, 1, 2047, 16, 1024, 300, 128};
    int unsigned        phase_items [PHASES]  = '{100, 20, 30, 90, 70, 90, 80, 75};

    first_fit_page_allocator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_command     (i_command),
        .i_count       (i_count),
        .i_page_index  (i_page_index),
        .i_null_handle (i_null_handle),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_first_page  (o_first_page)
    );

    ffpa_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_cmd_valid   (i_valid),
        .i_cmd_ready   (o_ready),
        .i_command     (i_command),
        .i_count       (i_count),
        .i_page_index  (i_page_index),
        .i_null_handle (i_null_handle),
        .i_res_valid   (o_valid),
        .i_res_ready   (i_ready),
        .i_status      (o_status),
        .i_first_page  (o_first_page),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [IDX_W-1:0] any_page();
        return IDX_W'($urandom_range(0, MAX_PAGES_DEF - 1));
    endfunction

    function automatic logic [CNT_W-1:0] any_count();
        return CNT_W'($urandom_range(0, 2047));
    endfunction

    function automatic logic any_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic pick_gap(inout int calm, output int gap);
        if (calm > 0) begin
            calm--;
            gap = 0;
        end else if ($urandom_range(0, 29) == 0) begin
            calm = $urandom_range(8, 30);
            gap = 0;
        end else begin
            gap = $urandom_range(0, 4);
        end
    endtask

    task automatic issue(input logic cmd, input logic [CNT_W-1:0] cnt,
                         input logic [IDX_W-1:0] idx, input logic is_null);
        int gap;
        pick_gap(send_calm, gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_count       <= cnt;
        i_page_index  <= idx;
        i_null_handle <= is_null;
        do @(posedge i_clk); while (!o_ready);
        sent_alloc.push_back(cmd == CMD_ALLOC);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_region(input int unsigned pages);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= CNT_W'(pages);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_cmd(input int unsigned usable);
        int unsigned      r;
        int unsigned      pick;
        logic [IDX_W-1:0] head;
        logic [CNT_W-1:0] cnt;
        r = $urandom_range(0, 99);
        if (r >= 50 && r < 85 && live_blocks.size() > 0) begin
            pick = $urandom_range(0, live_blocks.size() - 1);
            head = live_blocks[pick];
            live_blocks.delete(pick);
            issue(CMD_FREE, any_count(), head, 1'b0);
        end else if (r >= 85 && r < 90) begin
            issue(CMD_FREE, any_count(), any_page(), 1'b0);
        end else if (r >= 90 && r < 94) begin
            issue(CMD_FREE, any_count(), any_page(), 1'b1);
        end else if (r >= 94 && r < 97) begin
            issue(CMD_ALLOC, '0, any_page(), any_bit());
        end else if (r >= 97) begin
            issue(CMD_ALLOC, CNT_W'($urandom_range(usable + 1, 2047)), any_page(), any_bit());
        end else begin
            if ($urandom_range(0, 7) == 0) begin
                cnt = CNT_W'($urandom_range(1, (usable > 1) ? usable : 1));
            end else begin
                cnt = CNT_W'($urandom_range(1, 8));
            end
            issue(CMD_ALLOC, cnt, any_page(), any_bit());
        end
    endtask

    // harvest handles of successful allocations for later frees
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready && sent_alloc.size() > 0) begin
            if (sent_alloc.pop_front() && o_status == ST_OK) begin
                live_blocks.push_back(o_first_page);
            end
        end
    end

    initial begin : receiver
        int gap;
        int beats;
        beats = 0;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            // long hold-off once, so the block backs up onto its input
            if (beats == 200) begin
                gap = 400;
            end else begin
                pick_gap(recv_calm, gap);
            end
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            beats++;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        int unsigned usable;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        i_valid       <= 1'b0;
        i_command     <= CMD_ALLOC;
        i_count       <= '0;
        i_page_index  <= '0;
        i_null_handle <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed beats on the full region after reset
        issue(CMD_ALLOC, 11'd0,    any_page(), 1'b0);
        issue(CMD_ALLOC, 11'd1024, any_page(), 1'b0);
        issue(CMD_ALLOC, 11'd1,    any_page(), 1'b0);
        issue(CMD_FREE,  any_count(), 10'd0, 1'b0);
        issue(CMD_FREE,  any_count(), 10'd0, 1'b0);
        issue(CMD_FREE,  any_count(), 10'd1023, 1'b1);
        issue(CMD_ALLOC, 11'd1025, any_page(), 1'b0);
        issue(CMD_ALLOC, 11'd2047, 10'd1023, 1'b1);
        issue(CMD_ALLOC, 11'd3,    any_page(), 1'b0);
        issue(CMD_ALLOC, 11'd5,    any_page(), 1'b0);
        issue(CMD_FREE,  11'd2047, 10'd1, 1'b0);
        issue(CMD_ALLOC, 11'd2,    any_page(), 1'b0);
        issue(CMD_FREE,  any_count(), 10'd6, 1'b0);
        issue(CMD_FREE,  any_count(), 10'd3, 1'b0);
        issue(CMD_FREE,  any_count(), 10'd1023, 1'b0);
        issue(CMD_ALLOC, 11'd1,    any_page(), 1'b0);
        issue(CMD_ALLOC, 11'd1020, any_page(), 1'b0);
        issue(CMD_FREE,  any_count(), 10'd4, 1'b0);
        issue(CMD_FREE,  11'd2047, 10'd0, 1'b1);
        issue(CMD_ALLOC, 11'd2,    10'd1023, 1'b1);
        issue(CMD_FREE,  11'd0,    10'd0, 1'b0);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            repeat (16) @(posedge i_clk);
            write_region(phase_region[ph]);
            usable = (phase_region[ph] > MAX_PAGES_DEF) ? MAX_PAGES_DEF : phase_region[ph];
            for (int n = 0; n < phase_items[ph]; n++) begin
                if (n == phase_items[ph] / 2) begin
                    drain_results();
                end
                random_cmd(usable);
            end
        end

        drain_results();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sim.f
src/ffpa_pkg.sv
src/ffpa_mem.sv
src/ffpa_ctrl.sv
src/first_fit_page_allocator_core.sv
verif/ffpa_result_checker.sv
verif/tb.sv
